// ===== sv/quaternion_to_euler_angles_macros.svh =====
// Assertion macros for the quaternion to Euler angles block.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// Same-cycle implication, clocked on clock, disabled in reset.
`define QTE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qte: implication check failed");

// Implication after a fixed number of cycles.
`define QTE_ASSERT_AFTER(label, ante, cycles, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##cycles (cons)) \
      else $error("qte: latency check failed");

`endif

// ===== sv/qte_pkg.sv =====
// Package: types, constants and tables of the quaternion to Euler angles block.
package qte_pkg;

   localparam int DATA_WIDTH   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int WORK_WIDTH   = 64;
   localparam int WORK_SHIFT   = 59 - DATA_WIDTH;
   localparam int OUT_SHIFT    = 32 - DATA_WIDTH;
   localparam int TERM_WIDTH   = DATA_WIDTH + 2;
   localparam int LATENCY      = 2 * CORDIC_STEPS + 4;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] ROUND_HALF   = 32'(1) << (OUT_SHIFT - 1);

   localparam logic [1:0] CSR_AXIS_SEQUENCE      = 2'd0;
   localparam logic [1:0] CSR_SINGULAR_THRESHOLD = 2'd1;
   localparam logic [3:0] SEQ_LAST               = 4'd11;

   typedef enum logic [1:0] {
      STATUS_NORMAL    = 2'd0,
      STATUS_LOCK_ZERO = 2'd1,
      STATUS_LOCK_PI   = 2'd2,
      STATUS_ZERO_QUAT = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] qw;
      logic signed [DATA_WIDTH-1:0] qx;
      logic signed [DATA_WIDTH-1:0] qy;
      logic signed [DATA_WIDTH-1:0] qz;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] angle_first;
      logic signed [DATA_WIDTH-1:0] angle_middle;
      logic signed [DATA_WIDTH-1:0] angle_last;
      status_type                   status;
   } rsp_word_type;

   // Axis digits (1 = x, 2 = y, 3 = z); for proper sequences ak is the third axis.
   typedef struct packed {
      logic [1:0] ai;
      logic [1:0] aj;
      logic [1:0] ak;
      logic       proper;
      logic       eps_neg;
   } seq_type;

   // Per-item flags that travel down the pipeline.
   typedef struct packed {
      logic proper;
      logic eps_neg;
      logic zero_q;
      logic zero1;
      logic zero2;
   } side_type;

   function automatic seq_type seq_decode(input logic [3:0] code);
      seq_type s;
      unique case (code)
         4'd0:    s = '{2'd3, 2'd2, 2'd1, 1'b1, 1'b1};
         4'd1:    s = '{2'd3, 2'd1, 2'd2, 1'b1, 1'b0};
         4'd2:    s = '{2'd1, 2'd2, 2'd3, 1'b1, 1'b0};
         4'd3:    s = '{2'd1, 2'd3, 2'd2, 1'b1, 1'b1};
         4'd4:    s = '{2'd2, 2'd1, 2'd3, 1'b1, 1'b1};
         4'd5:    s = '{2'd2, 2'd3, 2'd1, 1'b1, 1'b0};
         4'd6:    s = '{2'd3, 2'd2, 2'd1, 1'b0, 1'b1};
         4'd7:    s = '{2'd3, 2'd1, 2'd2, 1'b0, 1'b0};
         4'd8:    s = '{2'd1, 2'd2, 2'd3, 1'b0, 1'b0};
         4'd9:    s = '{2'd1, 2'd3, 2'd2, 1'b0, 1'b1};
         4'd10:   s = '{2'd2, 2'd1, 2'd3, 1'b0, 1'b1};
         4'd11:   s = '{2'd2, 2'd3, 2'd1, 1'b0, 1'b0};
         default: s = '{2'd3, 2'd2, 2'd1, 1'b0, 1'b1};
      endcase
      return s;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] q_select(input req_word_type q,
                                                             input logic [1:0] idx);
      logic signed [DATA_WIDTH-1:0] r;
      case (idx)
         2'd1:    r = q.qx;
         2'd2:    r = q.qy;
         default: r = q.qz;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] atan_angle(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051E;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2FA;
         5'd15:   r = 32'h0000517D;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A30;
         5'd19:   r = 32'h00000518;
         5'd20:   r = 32'h0000028C;
         5'd21:   r = 32'h00000146;
         5'd22:   r = 32'h000000A3;
         5'd23:   r = 32'h00000051;
         5'd24:   r = 32'h00000029;
         5'd25:   r = 32'h00000014;
         5'd26:   r = 32'h0000000A;
         5'd27:   r = 32'h00000005;
         5'd28:   r = 32'h00000003;
         5'd29:   r = 32'h00000001;
         5'd30:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] to_out(input logic [31:0] z);
      logic [31:0] s;
      s = z + ROUND_HALF;
      return s[31:OUT_SHIFT];
   endfunction

endpackage

// ===== sv/quaternion_to_euler_angles.sv =====
// Top level: pipelined quaternion to Euler angle converter (direct method, CORDIC).
// One quaternion word is taken at every clock edge where start is high and busy is low;
// busy stays low, so a word may enter in every cycle. Each word gives one result word,
// shown on rsp_word for exactly one cycle with rsp_strobe high, after it has passed
// through one input register, one term/pre-rotation stage, the 16 paired CORDIC steps
// for atan2(b, a) and atan2(d, c), one stage that forms the magnitude vector, 16 CORDIC
// steps for the middle angle and one result register. The receiver cannot stall:
// results come out in input order and must be taken when shown.
// Write axis_sequence (index 0) and singular_threshold (index 1) through the csr port
// only while no words are in flight; sequence codes above 11 are ignored.
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles
   import qte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_data
);

   localparam int N = CORDIC_STEPS;

   // Configuration registers
   logic [3:0]  seq_ff;
   logic [14:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 4'd6;
         thr_ff <= 15'd2;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AXIS_SEQUENCE: begin
               // drop unused sequence codes
               if (csr_data[3:0] <= SEQ_LAST) seq_ff <= csr_data[3:0];
            end
            CSR_SINGULAR_THRESHOLD: thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Input register
   req_word_type q_ff;
   logic         q_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else       q_valid_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      q_ff <= req_word;
   end

   // Terms a, b, c, d and pre-rotation into the right half plane
   seq_type                       sq;
   logic signed [DATA_WIDTH-1:0]  qi, qj, qk;
   logic signed [TERM_WIDTH-1:0]  ta, tb, tc, td, ek;
   logic signed [WORK_WIDTH-1:0]  xa, yb, xc, yd;
   side_type                      side0_in;
   logic signed [WORK_WIDTH-1:0]  x1_0_in, y1_0_in, x2_0_in, y2_0_in;
   logic [31:0]                   z1_0_in, z2_0_in;

   always_comb begin
      sq = seq_decode(seq_ff);
      qi = q_select(q_ff, sq.ai);
      qj = q_select(q_ff, sq.aj);
      qk = q_select(q_ff, sq.ak);
      ek = sq.eps_neg ? -TERM_WIDTH'(qk) : TERM_WIDTH'(qk);
      if (sq.proper) begin
         ta = TERM_WIDTH'(q_ff.qw);
         tb = TERM_WIDTH'(qi);
         tc = TERM_WIDTH'(qj);
         td = ek;
      end else begin
         ta = TERM_WIDTH'(q_ff.qw) - TERM_WIDTH'(qj);
         tb = TERM_WIDTH'(qi) + ek;
         tc = TERM_WIDTH'(qj) + TERM_WIDTH'(q_ff.qw);
         td = ek - TERM_WIDTH'(qi);
      end
      xa = WORK_WIDTH'(ta) <<< WORK_SHIFT;
      yb = WORK_WIDTH'(tb) <<< WORK_SHIFT;
      xc = WORK_WIDTH'(tc) <<< WORK_SHIFT;
      yd = WORK_WIDTH'(td) <<< WORK_SHIFT;
      side0_in.proper  = sq.proper;
      side0_in.eps_neg = sq.eps_neg;
      side0_in.zero_q  = (q_ff.qw == '0) && (q_ff.qx == '0) && (q_ff.qy == '0)
                         && (q_ff.qz == '0);
      side0_in.zero1   = (ta == '0) && (tb == '0);
      side0_in.zero2   = (tc == '0) && (td == '0);
      // flip vectors with negative x by a half turn
      x1_0_in = xa[WORK_WIDTH-1] ? -xa : xa;
      y1_0_in = xa[WORK_WIDTH-1] ? -yb : yb;
      z1_0_in = xa[WORK_WIDTH-1] ? HALF_TURN : 32'd0;
      x2_0_in = xc[WORK_WIDTH-1] ? -xc : xc;
      y2_0_in = xc[WORK_WIDTH-1] ? -yd : yd;
      z2_0_in = xc[WORK_WIDTH-1] ? HALF_TURN : 32'd0;
   end

   // Paired CORDIC pipeline for atan2(b, a) and atan2(d, c)
   logic                          v1_ff    [0:N];
   side_type                      side1_ff [0:N];
   logic signed [WORK_WIDTH-1:0]  x1_ff    [0:N];
   logic signed [WORK_WIDTH-1:0]  y1_ff    [0:N];
   logic [31:0]                   z1_ff    [0:N];
   logic signed [WORK_WIDTH-1:0]  x2_ff    [0:N];
   logic signed [WORK_WIDTH-1:0]  y2_ff    [0:N];
   logic [31:0]                   z2_ff    [0:N];

   always_ff @(posedge clock) begin
      if (reset) v1_ff[0] <= 1'b0;
      else       v1_ff[0] <= q_valid_ff;
   end

   always_ff @(posedge clock) begin
      side1_ff[0] <= side0_in;
      x1_ff[0]    <= x1_0_in;
      y1_ff[0]    <= y1_0_in;
      z1_ff[0]    <= z1_0_in;
      x2_ff[0]    <= x2_0_in;
      y2_ff[0]    <= y2_0_in;
      z2_ff[0]    <= z2_0_in;
   end

   for (genvar g = 0; g < N; g++) begin : g_pair
      logic [31:0] atan_in;
      assign atan_in = atan_angle(5'(g));

      always_ff @(posedge clock) begin
         if (reset) v1_ff[g+1] <= 1'b0;
         else       v1_ff[g+1] <= v1_ff[g];
      end

      always_ff @(posedge clock) begin
         side1_ff[g+1] <= side1_ff[g];
         // rotate toward y = 0
         if (!y1_ff[g][WORK_WIDTH-1]) begin
            x1_ff[g+1] <= x1_ff[g] + (y1_ff[g] >>> g);
            y1_ff[g+1] <= y1_ff[g] - (x1_ff[g] >>> g);
            z1_ff[g+1] <= z1_ff[g] + atan_in;
         end else begin
            x1_ff[g+1] <= x1_ff[g] - (y1_ff[g] >>> g);
            y1_ff[g+1] <= y1_ff[g] + (x1_ff[g] >>> g);
            z1_ff[g+1] <= z1_ff[g] - atan_in;
         end
         if (!y2_ff[g][WORK_WIDTH-1]) begin
            x2_ff[g+1] <= x2_ff[g] + (y2_ff[g] >>> g);
            y2_ff[g+1] <= y2_ff[g] - (x2_ff[g] >>> g);
            z2_ff[g+1] <= z2_ff[g] + atan_in;
         end else begin
            x2_ff[g+1] <= x2_ff[g] - (y2_ff[g] >>> g);
            y2_ff[g+1] <= y2_ff[g] + (x2_ff[g] >>> g);
            z2_ff[g+1] <= z2_ff[g] - atan_in;
         end
      end
   end

   // Middle-angle CORDIC on the magnitude vector (|a,b|, |c,d|); x never goes negative
   logic                          v3_ff    [0:N];
   side_type                      side3_ff [0:N];
   logic                          zero3_ff [0:N];
   logic signed [WORK_WIDTH-1:0]  x3_ff    [0:N];
   logic signed [WORK_WIDTH-1:0]  y3_ff    [0:N];
   logic [31:0]                   z3_ff    [0:N];
   logic [31:0]                   tp_ff    [0:N];
   logic [31:0]                   tm_ff    [0:N];
   logic signed [WORK_WIDTH-1:0]  m_ab_in, m_cd_in;

   assign m_ab_in = side1_ff[N].zero1 ? '0 : x1_ff[N];
   assign m_cd_in = side1_ff[N].zero2 ? '0 : x2_ff[N];

   always_ff @(posedge clock) begin
      if (reset) v3_ff[0] <= 1'b0;
      else       v3_ff[0] <= v1_ff[N];
   end

   always_ff @(posedge clock) begin
      side3_ff[0] <= side1_ff[N];
      zero3_ff[0] <= (m_ab_in == '0) && (m_cd_in == '0);
      x3_ff[0]    <= m_ab_in;
      y3_ff[0]    <= m_cd_in;
      z3_ff[0]    <= 32'd0;
      tp_ff[0]    <= side1_ff[N].zero1 ? 32'd0 : z1_ff[N];
      tm_ff[0]    <= side1_ff[N].zero2 ? 32'd0 : z2_ff[N];
   end

   for (genvar g = 0; g < N; g++) begin : g_mid
      logic [31:0] atan_in;
      assign atan_in = atan_angle(5'(g));

      always_ff @(posedge clock) begin
         if (reset) v3_ff[g+1] <= 1'b0;
         else       v3_ff[g+1] <= v3_ff[g];
      end

      always_ff @(posedge clock) begin
         side3_ff[g+1] <= side3_ff[g];
         zero3_ff[g+1] <= zero3_ff[g];
         tp_ff[g+1]    <= tp_ff[g];
         tm_ff[g+1]    <= tm_ff[g];
         if (!y3_ff[g][WORK_WIDTH-1]) begin
            x3_ff[g+1] <= x3_ff[g] + (y3_ff[g] >>> g);
            y3_ff[g+1] <= y3_ff[g] - (x3_ff[g] >>> g);
            z3_ff[g+1] <= z3_ff[g] + atan_in;
         end else begin
            x3_ff[g+1] <= x3_ff[g] - (y3_ff[g] >>> g);
            y3_ff[g+1] <= y3_ff[g] + (x3_ff[g] >>> g);
            z3_ff[g+1] <= z3_ff[g] - atan_in;
         end
      end
   end

   // Combine: clamp the middle angle, test for gimbal lock, form the output word
   logic [31:0]  phi, e1, e2, e3;
   logic [32:0]  t2, t2_pi, thr33;
   status_type   st;
   rsp_word_type rsp_in;

   always_comb begin
      phi = zero3_ff[N] ? 32'd0 : z3_ff[N];
      // a slightly negative result reads as zero; cap at a quarter turn
      if (phi >= HALF_TURN)         phi = 32'd0;
      else if (phi > QUARTER_TURN)  phi = QUARTER_TURN;
      t2    = {phi, 1'b0};
      t2_pi = 33'(HALF_TURN) - t2;
      thr33 = 33'(thr_ff) << OUT_SHIFT;
      if (t2 <= thr33) begin
         st = STATUS_LOCK_ZERO;
         e1 = 32'd0;
         e3 = tp_ff[N] + tp_ff[N];
      end else if (t2_pi <= thr33) begin
         st = STATUS_LOCK_PI;
         e1 = 32'd0;
         e3 = tm_ff[N] + tm_ff[N];
      end else begin
         st = STATUS_NORMAL;
         e1 = tp_ff[N] - tm_ff[N];
         e3 = tp_ff[N] + tm_ff[N];
      end
      e2 = t2[31:0];
      if (!side3_ff[N].proper) begin
         if (side3_ff[N].eps_neg) e3 = 32'd0 - e3;
         e2 = e2 - QUARTER_TURN;
      end
      if (side3_ff[N].zero_q) begin
         rsp_in.angle_first  = '0;
         rsp_in.angle_middle = '0;
         rsp_in.angle_last   = '0;
         rsp_in.status       = STATUS_ZERO_QUAT;
      end else begin
         rsp_in.angle_first  = to_out(e1);
         rsp_in.angle_middle = to_out(e2);
         rsp_in.angle_last   = to_out(e3);
         rsp_in.status       = st;
      end
   end

   // Result register: hold each word for one cycle under the strobe
   logic         rsp_strobe_ff;
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= v3_ff[N];
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Terms for the checks on the result word
   logic rsp_zero_angles;
   logic rsp_locked;

   assign rsp_zero_angles = (rsp_word.angle_first == '0) && (rsp_word.angle_middle == '0)
                            && (rsp_word.angle_last == '0);
   assign rsp_locked      = (rsp_word.status == STATUS_LOCK_ZERO)
                            || (rsp_word.status == STATUS_LOCK_PI);

   // Every accepted word yields a strobe a fixed latency later, and nothing else does
   `QTE_ASSERT_AFTER(a_latency, start && !busy, LATENCY, rsp_strobe)
   `QTE_ASSERT_AFTER(a_no_extra, !(start && !busy), LATENCY, !rsp_strobe)
   `QTE_ASSERT_IMPLY(a_zero_quat, rsp_strobe && rsp_word.status == STATUS_ZERO_QUAT, rsp_zero_angles)
   `QTE_ASSERT_IMPLY(a_lock_first, rsp_strobe && rsp_locked, rsp_word.angle_first == '0)

endmodule
